// ===== hw/rtl/hpg_pkg.sv =====
// shared constants and types for the halton point generator
package hpg_pkg;

  localparam int INDEX_BITS    = 24;
  localparam int FRACTION_BITS = 16;

  localparam int BASE_W   = 8;
  localparam int OFFSET_W = FRACTION_BITS + 1;
  localparam int OUT_W    = FRACTION_BITS + 1;

  // n + 1 carries into one extra bit
  localparam int M_W      = INDEX_BITS + 1;
  localparam int DIGIT_W  = 4;
  localparam int NCHUNK   = (M_W + DIGIT_W - 1) / DIGIT_W;
  localparam int MR_W     = NCHUNK * DIGIT_W;
  // den = b^k is at most b * m
  localparam int DEN_W    = M_W + BASE_W;

  localparam int CHUNK_CNT_W = $clog2(NCHUNK);
  localparam int FRAC_CNT_W  = $clog2(FRACTION_BITS);

  localparam int IN_TDATA_W  = ((INDEX_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((2 * OUT_W + 7) / 8) * 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = OFFSET_W;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_X       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_Y       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_OFFSET = 2'd2;

  localparam logic [BASE_W-1:0] BASE_MIN     = 8'd2;
  localparam logic [BASE_W-1:0] BASE_X_RESET = 8'd2;
  localparam logic [BASE_W-1:0] BASE_Y_RESET = 8'd3;

  typedef struct packed {
    logic start;
    logic take;
  } lane_ctl_t;

endpackage

// ===== hw/rtl/hpg_lane.sv =====
// one coordinate: digit-serial base-b digit extraction, then bit-serial fraction division
module hpg_lane (
  input  logic                             clk,
  input  logic                             rst_n,
  input  hpg_pkg::lane_ctl_t               ctl,
  input  logic [hpg_pkg::M_W-1:0]          m_in,
  input  logic [hpg_pkg::BASE_W-1:0]       base_in,
  output logic                             done,
  output logic [hpg_pkg::FRACTION_BITS-1:0] frac
);
  import hpg_pkg::*;

  typedef enum logic [4:0] {
    L_IDLE = 5'b00001,
    L_DIV  = 5'b00010,
    L_ACC  = 5'b00100,
    L_FRAC = 5'b01000,
    L_DONE = 5'b10000
  } lane_state_t;

  lane_state_t state_r, state_nxt;

  logic [MR_W-1:0]          m_r, m_nxt;
  logic [BASE_W-1:0]        rem_r, rem_nxt;
  logic [BASE_W-1:0]        b_r, b_nxt;
  logic [CHUNK_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [DEN_W-1:0]         num_r, num_nxt;
  logic [DEN_W-1:0]         den_r, den_nxt;
  logic [DEN_W-1:0]         fr_r, fr_nxt;
  logic [FRACTION_BITS-1:0] q_r, q_nxt;
  logic [FRAC_CNT_W-1:0]    fcnt_r, fcnt_nxt;

  logic [DIGIT_W-1:0]       chunk;
  logic [DIGIT_W-1:0]       qd;
  logic [BASE_W:0]          t;
  logic [BASE_W-1:0]        r;
  logic [BASE_W-1:0]        div_rem;

  logic [DEN_W+BASE_W-1:0]  num_prod;
  logic [DEN_W+BASE_W-1:0]  den_prod;
  logic [DEN_W:0]           fs;
  logic                     fge;

  // one digit of m / b per cycle, restoring steps on a narrow remainder
  always_comb begin
    chunk = m_r[MR_W-1 -: DIGIT_W];
    r     = rem_r;
    qd    = '0;
    t     = '0;
    for (int j = DIGIT_W - 1; j >= 0; j--) begin
      t = {r, chunk[j]};
      if (t >= {1'b0, b_r}) begin
        qd[j] = 1'b1;
        r     = BASE_W'(t - {1'b0, b_r});
      end else begin
        r     = t[BASE_W-1:0];
      end
    end
    div_rem = r;
  end

  assign num_prod = (DEN_W+BASE_W)'(num_r) * (DEN_W+BASE_W)'(b_r)
                  + (DEN_W+BASE_W)'(rem_r);
  assign den_prod = (DEN_W+BASE_W)'(den_r) * (DEN_W+BASE_W)'(b_r);

  assign fs  = {fr_r, 1'b0};
  assign fge = fs >= {1'b0, den_r};

  always_comb begin
    state_nxt = state_r;
    m_nxt     = m_r;
    rem_nxt   = rem_r;
    b_nxt     = b_r;
    cnt_nxt   = cnt_r;
    num_nxt   = num_r;
    den_nxt   = den_r;
    fr_nxt    = fr_r;
    q_nxt     = q_r;
    fcnt_nxt  = fcnt_r;
    unique case (state_r)
      L_IDLE: begin
        if (ctl.start) begin
          m_nxt     = MR_W'(m_in);
          rem_nxt   = '0;
          b_nxt     = (base_in < BASE_MIN) ? BASE_MIN : base_in;
          cnt_nxt   = '0;
          num_nxt   = '0;
          den_nxt   = DEN_W'(1);
          state_nxt = L_DIV;
        end
      end
      L_DIV: begin
        m_nxt   = {m_r[MR_W-DIGIT_W-1:0], qd};
        rem_nxt = div_rem;
        cnt_nxt = cnt_r + CHUNK_CNT_W'(1);
        if (cnt_r == CHUNK_CNT_W'(NCHUNK - 1)) begin
          state_nxt = L_ACC;
        end
      end
      L_ACC: begin
        // append the digit: num = num*b + digit, den = den*b
        num_nxt = num_prod[DEN_W-1:0];
        den_nxt = den_prod[DEN_W-1:0];
        rem_nxt = '0;
        cnt_nxt = '0;
        if (m_r == '0) begin
          fr_nxt    = num_prod[DEN_W-1:0];
          q_nxt     = '0;
          fcnt_nxt  = '0;
          state_nxt = L_FRAC;
        end else begin
          state_nxt = L_DIV;
        end
      end
      L_FRAC: begin
        q_nxt    = {q_r[FRACTION_BITS-2:0], fge};
        fr_nxt   = fge ? DEN_W'(fs - {1'b0, den_r}) : fs[DEN_W-1:0];
        fcnt_nxt = fcnt_r + FRAC_CNT_W'(1);
        if (fcnt_r == FRAC_CNT_W'(FRACTION_BITS - 1)) begin
          state_nxt = L_DONE;
        end
      end
      L_DONE: begin
        if (ctl.take) begin
          state_nxt = L_IDLE;
        end
      end
      default: begin
        state_nxt = L_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_r    <= m_nxt;
    rem_r  <= rem_nxt;
    b_r    <= b_nxt;
    cnt_r  <= cnt_nxt;
    num_r  <= num_nxt;
    den_r  <= den_nxt;
    fr_r   <= fr_nxt;
    q_r    <= q_nxt;
    fcnt_r <= fcnt_nxt;
  end

  assign done = (state_r == L_DONE);
  assign frac = q_r;

endmodule

// ===== hw/rtl/halton_point_generator_top.sv =====
// halton point generator top level: config registers, two coordinate lanes, output register
//
//  channel  direction  signals                                   payload
//  in       slave      in_tvalid / in_tready / in_tdata          sample_number
//  out      master     out_tvalid / out_tready / out_tdata       x_value, y_value
//  cfg      slave      cfg_valid / cfg_ready / cfg_index / data  base_x, base_y, point_offset
//
// one item at a time; the digit count of n+1 in the smaller base sets how long an item takes:
// each digit takes a pass of the 4-bit divider over all chunks of m and an accumulate step,
// then come bit-serial fraction division and the load into the output register
// the next item is taken while a result waits in the output register
// synchronous active-low reset clears the lanes and the output valid, resets the registers
module halton_point_generator_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [23:0] sample_number
  input  logic [hpg_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [16:0] x_value, [33:17] y_value, [39:34] zero
  output logic [hpg_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [hpg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hpg_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import hpg_pkg::*;

  localparam logic signed [OUT_W:0] LOWEST = $signed({2'b11, {FRACTION_BITS{1'b0}}});

  logic [BASE_W-1:0]   base_x_r, base_y_r;
  logic [OFFSET_W-1:0] offset_r;
  logic                busy_r;
  logic                out_valid_r;
  logic [OUT_W-1:0]    out_x_r, out_y_r;

  lane_ctl_t                ctl;
  logic [M_W-1:0]           m_in;
  logic                     done_x, done_y;
  logic [FRACTION_BITS-1:0] frac_x, frac_y;
  logic                     in_xfer, load;
  logic signed [OUT_W:0]    dx, dy;
  logic [OUT_W-1:0]         x_res, y_res;

  assign in_tready = !busy_r;
  assign in_xfer   = in_tvalid && in_tready;
  assign load      = done_x && done_y && (!out_valid_r || out_tready);
  assign m_in      = M_W'(in_tdata[INDEX_BITS-1:0]) + M_W'(1);

  assign ctl.start = in_xfer;
  assign ctl.take  = load;

  hpg_lane u_lane_x (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .m_in    (m_in),
    .base_in (base_x_r),
    .done    (done_x),
    .frac    (frac_x)
  );

  hpg_lane u_lane_y (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .m_in    (m_in),
    .base_in (base_y_r),
    .done    (done_y),
    .frac    (frac_y)
  );

  // subtract offset, saturate at -1.0
  always_comb begin
    dx    = $signed({2'b00, frac_x}) - $signed({1'b0, offset_r});
    dy    = $signed({2'b00, frac_y}) - $signed({1'b0, offset_r});
    x_res = (dx < LOWEST) ? LOWEST[OUT_W-1:0] : dx[OUT_W-1:0];
    y_res = (dy < LOWEST) ? LOWEST[OUT_W-1:0] : dy[OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        busy_r <= 1'b1;
      end else if (load) begin
        busy_r <= 1'b0;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_x_r <= x_res;
      out_y_r <= y_res;
    end
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_x_r <= BASE_X_RESET;
      base_y_r <= BASE_Y_RESET;
      offset_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BASE_X:       base_x_r <= cfg_data[BASE_W-1:0];
        REG_BASE_Y:       base_y_r <= cfg_data[BASE_W-1:0];
        REG_POINT_OFFSET: offset_r <= cfg_data[OFFSET_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_y_r, out_x_r});

endmodule

// ===== hw/rtl/hpg_checker.sv =====
// port-level checks for the halton point generator top level
module hpg_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [hpg_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            cfg_valid,
  input logic                            cfg_ready
);
  import hpg_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // reset empties the output register
  a_out_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // one item in flight: an input transfer closes the input side
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while an item is in flight");

  // a new result frees the input side in the same step
  a_result_frees: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> in_tready)
    else $error("input still blocked after result was loaded");

  // config port never stalls
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("config write stalled");

endmodule

bind halton_point_generator_top hpg_checker u_hpg_checker (.*);

// ===== verif/tb_top.sv =====
// testbench for the halton point generator: directed and random samples checked against a predictor
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hpg_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int HOLD_CYCLES  = 600;
  localparam int DRAIN_CYCLES = 4;
  // covers the longest item, n+1 of 25 digits in base 2, plus margin
  localparam int TAIL_CYCLES  = 240;
  localparam int RANDOM_PHASES    = 8;
  localparam int ITEMS_PER_PHASE  = 80;
  localparam int MAX_REPORTED     = 10;

  // index 3 is not mapped to any register
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  typedef struct packed {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
  } point_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } reg_write_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;

  // shadow copy of the block's registers
  logic [BASE_W-1:0]   base_x_q = BASE_X_RESET;
  logic [BASE_W-1:0]   base_y_q = BASE_Y_RESET;
  logic [OFFSET_W-1:0] offset_q = '0;

  point_t     pending_points[$];
  reg_write_t register_writes[$];

  int  fail_count   = 0;
  int  cycle_count  = 0;
  bit  steady_flow  = 1'b0;
  bit  sink_steady  = 1'b0;
  bit  hold_request = 1'b0;
  logic hold_off    = 1'b0;

  halton_point_generator_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  initial begin : watchdog
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // mirrored base-b digits of m, truncated to FRACTION_BITS fractional bits
  function automatic longint unsigned reflect_fraction(input longint unsigned m,
                                                      input logic [BASE_W-1:0] radix);
    longint unsigned b, num, den, rem, q;
    int i;
    b   = 64'((radix < BASE_MIN) ? BASE_MIN : radix);
    num = 0;
    den = 1;
    q   = 0;
    while (m > 0) begin
      num = num * b + m % b;
      den = den * b;
      m   = m / b;
    end
    rem = num;
    for (i = 0; i < FRACTION_BITS; i++) begin
      rem = rem << 1;
      q   = q << 1;
      if (rem >= den) begin
        rem = rem - den;
        q   = q | 1;
      end
    end
    return q;
  endfunction

  function automatic logic signed [OUT_W-1:0] shift_by_offset(input longint unsigned coord);
    longint diff;
    diff = longint'(coord) - longint'(offset_q);
    if (diff < -(longint'(1) << FRACTION_BITS)) diff = -(longint'(1) << FRACTION_BITS);
    return diff[OUT_W-1:0];
  endfunction

  function automatic point_t predict_point(input logic [INDEX_BITS-1:0] n);
    point_t p;
    longint unsigned m;
    m   = longint'(n) + 1;
    p.x = shift_by_offset(reflect_fraction(m, base_x_q));
    p.y = shift_by_offset(reflect_fraction(m, base_y_q));
    return p;
  endfunction

  function automatic void note_failure(input string what);
    fail_count++;
    if (fail_count <= MAX_REPORTED) $display("mismatch: %s", what);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(12, 60);
  endfunction

  task automatic check_point(input logic [OUT_TDATA_W-1:0] word);
    point_t want;
    logic signed [OUT_W-1:0] got_x, got_y;
    got_x = word[OUT_W-1:0];
    got_y = word[2*OUT_W-1:OUT_W];
    if (pending_points.size() == 0) begin
      note_failure($sformatf("unexpected result x %0d y %0d", got_x, got_y));
      return;
    end
    want = pending_points.pop_front();
    if (got_x !== want.x)
      note_failure($sformatf("x_value expected %0d got %0d", want.x, got_x));
    if (got_y !== want.y)
      note_failure($sformatf("y_value expected %0d got %0d", want.y, got_y));
  endtask

  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) check_point(out_tdata);
      if (stall_left > 0) stall_left--;
      else if (!sink_steady) stall_left = pick_gap();
      out_tready <= rst_n && !hold_off && (stall_left == 0);
    end
  end

  // long receiver hold-off, started on request
  initial begin : hold_timer
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
      end
    end
  end

  task automatic send_sample(input logic [INDEX_BITS-1:0] n);
    int gap;
    gap = steady_flow ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= IN_TDATA_W'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'(n);
    do @(posedge clk); while (!in_tready);
    pending_points.push_back(predict_point(n));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic void stage_write(input logic [CFG_IDX_W-1:0] index,
                                      input logic [CFG_DATA_W-1:0] data);
    reg_write_t w;
    w.index = index;
    w.data  = data;
    register_writes.push_back(w);
  endfunction

  task automatic flush_config();
    reg_write_t w;
    while (register_writes.size() != 0) begin
      w = register_writes.pop_front();
      cfg_valid <= 1'b1;
      cfg_index <= w.index;
      cfg_data  <= w.data;
      do @(posedge clk); while (!cfg_ready);
      case (w.index)
        REG_BASE_X:       base_x_q = w.data[BASE_W-1:0];
        REG_BASE_Y:       base_y_q = w.data[BASE_W-1:0];
        REG_POINT_OFFSET: offset_q = w.data;
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_sample(24'd0);
    send_sample(24'd1);
    send_sample(24'd2);
    send_sample(24'd7);
    send_sample(24'h7FFFFF);
    send_sample(24'hAAAAAA);
    send_sample(24'h555555);
    // n + 1 carries into the extra bit
    send_sample(24'hFFFFFF);
    wait_drained();
  endtask

  task automatic test_base_extremes();
    stage_write(REG_BASE_X, 17'h1_00FF);
    stage_write(REG_BASE_Y, 17'h0_0002);
    stage_write(REG_POINT_OFFSET, 17'd0);
    flush_config();
    send_sample(24'd0);
    send_sample(24'd253);
    send_sample(24'd254);
    send_sample(24'hFFFFFF);
    wait_drained();
    // bases of zero and one fall back to two; upper data bits are dropped
    stage_write(REG_BASE_X, 17'h0_FF00);
    stage_write(REG_BASE_Y, 17'h1_0001);
    flush_config();
    send_sample(24'd5);
    send_sample(24'hFFFFFE);
    wait_drained();
  endtask

  task automatic test_offset_and_saturation();
    stage_write(REG_BASE_X, 17'd7);
    stage_write(REG_BASE_Y, 17'd13);
    stage_write(REG_POINT_OFFSET, 17'd65536);
    flush_config();
    send_sample(24'd0);
    send_sample(24'd99);
    wait_drained();
    // offset beyond one saturates at the lowest output value
    stage_write(REG_POINT_OFFSET, 17'h1_FFFF);
    flush_config();
    send_sample(24'd0);
    send_sample(24'hFFFFFF);
    wait_drained();
    stage_write(REG_BASE_X, 17'd2);
    stage_write(REG_POINT_OFFSET, 17'd32768);
    flush_config();
    send_sample(24'd0);
    send_sample(24'd1);
    wait_drained();
  endtask

  task automatic test_unmapped_register();
    stage_write(REG_UNMAPPED, 17'h1_2345);
    flush_config();
    send_sample(24'd3);
    send_sample(24'd1000);
    wait_drained();
  endtask

  task automatic test_backpressure();
    int i;
    steady_flow  = 1'b1;
    hold_request = 1'b1;
    for (i = 0; i < 12; i++) send_sample(IN_TDATA_W'($urandom));
    steady_flow = 1'b0;
    wait_drained();
  endtask

  function automatic logic [BASE_W-1:0] pick_base();
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return 8'd1;
      2:       return 8'd2;
      3:       return 8'd255;
      4:       return 8'($urandom_range(2, 5));
      default: return 8'($urandom_range(2, 255));
    endcase
  endfunction

  task automatic stage_random_setting(input int phase);
    logic [BASE_W-1:0]   bx, by;
    logic [OFFSET_W-1:0] off;
    logic [CFG_DATA_W-BASE_W-1:0] junk_x, junk_y;
    junk_x = (CFG_DATA_W-BASE_W)'($urandom);
    junk_y = (CFG_DATA_W-BASE_W)'($urandom);
    case (phase)
      0: begin
        bx  = 8'd255;
        by  = 8'd255;
        off = 17'd65536;
      end
      1: begin
        bx  = 8'd2;
        by  = 8'd2;
        off = '1;
      end
      default: begin
        bx = pick_base();
        by = pick_base();
        case ($urandom_range(0, 3))
          0:       off = '0;
          1:       off = 17'($urandom_range(0, 65536));
          2:       off = 17'($urandom);
          default: off = 17'($urandom_range(0, 4096));
        endcase
      end
    endcase
    stage_write(REG_BASE_X, {junk_x, bx});
    if ($urandom_range(0, 3) == 0) stage_write(REG_UNMAPPED, 17'($urandom));
    stage_write(REG_BASE_Y, {junk_y, by});
    stage_write(REG_POINT_OFFSET, off);
  endtask

  function automatic logic [INDEX_BITS-1:0] pick_sample();
    longint unsigned b, p;
    int k;
    case ($urandom_range(0, 9))
      0, 1, 2: return 24'($urandom_range(0, 300));
      3, 4, 5: return 24'($urandom);
      6:       return 24'hFFFFFF - 24'($urandom_range(0, 15));
      7:       return 24'($urandom_range(0, 65535));
      default: begin
        // n+1 at exact powers of a base and at the all-top-digit values below them
        b = 64'(($urandom_range(0, 1) == 0) ? base_x_q : base_y_q);
        if (b < BASE_MIN) b = 64'(BASE_MIN);
        p = 1;
        k = $urandom_range(1, 24);
        while (k > 0 && p * b <= 64'h100_0000) begin
          p = p * b;
          k--;
        end
        if (p >= 2 && $urandom_range(0, 1) == 0) return 24'(p - 2);
        return 24'(p - 1);
      end
    endcase
  endfunction

  task automatic test_random_settings();
    int phase, i;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      stage_random_setting(phase);
      flush_config();
      steady_flow = (phase % 4 == 1);
      sink_steady = (phase % 4 == 2);
      for (i = 0; i < ITEMS_PER_PHASE; i++) send_sample(pick_sample());
      wait_drained();
    end
    steady_flow = 1'b0;
    sink_steady = 1'b0;
  endtask

  initial begin : test_sequence
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_base_extremes();
    test_offset_and_saturation();
    test_unmapped_register();
    test_backpressure();
    test_random_settings();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    fail_count += pending_points.size();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
